FILE: src/lockable_output_bank_assert.svh
// Assertion macros for the lockable output bank checker.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef LOCKABLE_OUTPUT_BANK_ASSERT_SVH
`define LOCKABLE_OUTPUT_BANK_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define OLB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("olb checker: same-cycle property violated");

// Next-cycle implication, disabled while in reset.
`define OLB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("olb checker: next-cycle property violated");

`endif

FILE: src/olb_pkg.sv
// Shared types and constants for the lockable output bank.
// No dependencies; every module here imports this package.
`default_nettype none

package olb_pkg;

    localparam int BANK_WIDTH          = 24;
    localparam int DEFAULT_NUM_OUTPUTS = 24;
    localparam int ID_WIDTH            = 11;
    localparam int FRAME_ID_WIDTH      = 29;
    localparam int LEN_WIDTH           = 4;
    localparam int CMD_WIDTH           = 3;
    localparam int REPLY_ID_WIDTH      = 12;

    localparam logic [LEN_WIDTH-1:0] FRAME_LEN = LEN_WIDTH'(7);

    localparam logic KIND_FRAME  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [CMD_WIDTH-1:0] CMD_SET         = CMD_WIDTH'(0);
    localparam logic [CMD_WIDTH-1:0] CMD_TOGGLE      = CMD_WIDTH'(1);
    localparam logic [CMD_WIDTH-1:0] CMD_LOCK_SET    = CMD_WIDTH'(2);
    localparam logic [CMD_WIDTH-1:0] CMD_LOCK_REMOVE = CMD_WIDTH'(3);

    // Configuration register indexes
    localparam logic REG_DEVICE_ID  = 1'b0;
    localparam logic REG_WIRED_MASK = 1'b1;

    typedef struct packed {
        logic                      kind;
        logic [FRAME_ID_WIDTH-1:0] frame_id;
        logic                      is_extended;
        logic [LEN_WIDTH-1:0]      frame_length;
        logic [CMD_WIDTH-1:0]      command;
        logic [BANK_WIDTH-1:0]     select_mask;
        logic [BANK_WIDTH-1:0]     value_bits;
    } item_t;

    typedef struct packed {
        logic [BANK_WIDTH-1:0]     output_levels;
        logic [BANK_WIDTH-1:0]     lock_mask;
        logic                      is_status_reply;
        logic [REPLY_ID_WIDTH-1:0] reply_id;
    } result_t;

    typedef struct packed {
        logic                  index;
        logic [BANK_WIDTH-1:0] data;
    } cfg_write_t;

    typedef struct packed {
        logic [ID_WIDTH-1:0]   device_id;
        logic [BANK_WIDTH-1:0] wired_mask;
    } cfg_t;

endpackage

`default_nettype wire

FILE: src/olb_stream_if.sv
// Valid/ready channel carrying one payload per transaction.
// Payload type is set per instance; used for item, result and config channels.
`default_nettype none

interface olb_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

FILE: src/olb_cfg_regs.sv
// Configuration registers (device id, wired mask) of the output bank.
// Depends on olb_pkg and olb_stream_if.
`default_nettype none

module olb_cfg_regs (
    input  wire logic    clk,
    input  wire logic    rst_n,
    olb_stream_if.sink   cfg,
    output olb_pkg::cfg_t cfg_out
);
    import olb_pkg::*;

    logic [ID_WIDTH-1:0]   device_id_reg;
    logic [BANK_WIDTH-1:0] wired_mask_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_id_reg  <= '0;
            wired_mask_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.payload.index)
                REG_DEVICE_ID:  device_id_reg  <= cfg.payload.data[ID_WIDTH-1:0];
                REG_WIRED_MASK: wired_mask_reg <= cfg.payload.data;
                default:        ;
            endcase
        end
    end

    assign cfg_out.device_id  = device_id_reg;
    assign cfg_out.wired_mask = wired_mask_reg;

endmodule

`default_nettype wire

FILE: src/olb_update.sv
// Frame filter, command decode and bank update for one item.
// Pure combinational; depends on olb_pkg.
`default_nettype none

module olb_update #(
    parameter int NUM_OUTPUTS = olb_pkg::DEFAULT_NUM_OUTPUTS
) (
    input  wire olb_pkg::item_t    item,
    input  wire olb_pkg::cfg_t     cfg,
    input  wire logic [NUM_OUTPUTS-1:0] level,
    input  wire logic [NUM_OUTPUTS-1:0] lock,
    output logic [NUM_OUTPUTS-1:0] level_next,
    output logic [NUM_OUTPUTS-1:0] lock_next,
    output olb_pkg::result_t       result
);
    import olb_pkg::*;

    logic                   hit;
    logic                   status;
    logic [NUM_OUTPUTS-1:0] sel;
    logic [NUM_OUTPUTS-1:0] val;
    logic [NUM_OUTPUTS-1:0] free;

    assign status = (item.kind == KIND_STATUS);
    assign hit    = (item.kind == KIND_FRAME)
                 && (item.frame_id == FRAME_ID_WIDTH'(cfg.device_id))
                 && !item.is_extended
                 && (item.frame_length == FRAME_LEN);

    assign sel  = item.select_mask[NUM_OUTPUTS-1:0] & cfg.wired_mask[NUM_OUTPUTS-1:0];
    assign val  = item.value_bits[NUM_OUTPUTS-1:0];
    assign free = sel & ~lock;

    always_comb
    begin
        level_next = level;
        lock_next  = lock;
        if (hit)
        begin
            case (item.command)
                CMD_SET:         level_next = (level & ~free) | (val & free);
                CMD_TOGGLE:      level_next = level ^ free;
                CMD_LOCK_SET:
                begin
                    lock_next  = lock | sel;
                    level_next = (level & ~sel) | (val & sel);
                end
                CMD_LOCK_REMOVE: lock_next = lock & ~sel;
                default:         ;
            endcase
        end
    end

    // Unwired outputs keep their level but report low
    assign result.output_levels   = BANK_WIDTH'(level_next) & cfg.wired_mask;
    assign result.lock_mask       = BANK_WIDTH'(lock_next);
    assign result.is_status_reply = status;
    assign result.reply_id        = status
                                  ? REPLY_ID_WIDTH'(cfg.device_id) + REPLY_ID_WIDTH'(1)
                                  : '0;

endmodule

`default_nettype wire

FILE: src/lockable_output_bank.sv
// Lockable output bank: a bank of NUM_OUTPUTS output levels with a lock bit each,
// driven by command frames and status requests on the item channel, one result per
// transaction on the result channel. Items are taken one per clock unless a stalled
// result holds them, as the whole bank updates in parallel in one combinational pass.
// Each result passes through the input register, then the result register; the level
// and lock registers are updated in the same cycle as the result register, so the next
// item always sees the previous item's effect. A stalled result holds the pipeline; the
// input register can still take one more item while the result waits, if it is empty.
// Configuration writes are accepted every cycle and take effect the cycle after.
// Depends on olb_pkg, olb_stream_if, olb_cfg_regs and olb_update.
`default_nettype none

module lockable_output_bank #(
    parameter int NUM_OUTPUTS = olb_pkg::DEFAULT_NUM_OUTPUTS
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    olb_stream_if.sink   item,
    olb_stream_if.source result,
    olb_stream_if.sink   cfg
);
    import olb_pkg::*;

    cfg_t                   cfg_cur;
    logic                   in_valid_reg;
    item_t                  in_item_reg;
    logic                   out_valid_reg;
    result_t                out_result_reg;
    logic [NUM_OUTPUTS-1:0] level_reg;
    logic [NUM_OUTPUTS-1:0] lock_reg;
    logic [NUM_OUTPUTS-1:0] level_next;
    logic [NUM_OUTPUTS-1:0] lock_next;
    result_t                result_next;
    logic                   advance;
    logic                   fire;

    olb_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_cur)
    );

    olb_update #(
        .NUM_OUTPUTS (NUM_OUTPUTS)
    ) u_update (
        .item       (in_item_reg),
        .cfg        (cfg_cur),
        .level      (level_reg),
        .lock       (lock_reg),
        .level_next (level_next),
        .lock_next  (lock_next),
        .result     (result_next)
    );

    assign advance    = !out_valid_reg || result.ready;
    assign fire       = in_valid_reg && advance;
    assign item.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            level_reg     <= '0;
            lock_reg      <= '0;
        end
        else
        begin
            if (item.ready)
            begin
                in_valid_reg <= item.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                level_reg <= level_next;
                lock_reg  <= lock_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_item_reg <= item.payload;
        end
        if (fire)
        begin
            out_result_reg <= result_next;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_result_reg;

endmodule

`default_nettype wire

FILE: src/olb_checker.sv
// Port-level checker for the lockable output bank, bound to the top level.
// Depends on olb_pkg and lockable_output_bank_assert.svh.
`default_nettype none

module olb_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             item_valid,
    input wire logic             item_ready,
    input wire logic             result_valid,
    input wire logic             result_ready,
    input wire olb_pkg::result_t result_payload
);
    import olb_pkg::*;

    `include "lockable_output_bank_assert.svh"

    logic stalled;
    logic status_out;
    logic frame_out;

    assign stalled    = result_valid && !result_ready;
    assign status_out = result_valid && result_payload.is_status_reply;
    assign frame_out  = result_valid && !result_payload.is_status_reply;

    // Stalled result must hold
    `OLB_ASSERT_NEXT(a_result_hold, stalled, result_valid && $stable(result_payload))

    // Only status replies carry an identifier, and it is never zero
    `OLB_ASSERT_NOW(a_frame_no_id, frame_out, result_payload.reply_id == '0)
    `OLB_ASSERT_NOW(a_status_id, status_out, result_payload.reply_id != '0)

    // Item taken during a stall fills the input register: no second one while the stall lasts
    `OLB_ASSERT_NEXT(a_stall_fills, stalled && item_valid && item_ready, result_ready || !item_ready)

endmodule

bind lockable_output_bank olb_checker u_olb_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item.valid),
    .item_ready     (item.ready),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_payload (result.payload)
);

`default_nettype wire

FILE: sim/lockable_output_bank_test.sv
// Self-checking testbench for lockable_output_bank: frames and status requests in,
// bank snapshots out. Uses olb_pkg and olb_stream_if from src; own predictor.
`timescale 1ns / 1ps

module lockable_output_bank_test;

    import olb_pkg::*;

    localparam logic [BANK_WIDTH-1:0] OUT_MASK =
        BANK_WIDTH'((64'd1 << DEFAULT_NUM_OUTPUTS) - 64'd1);
    localparam int RANDOM_PHASES    = 6;
    localparam int ITEMS_PER_PHASE  = 135;

    logic clk = 1'b0;
    logic rst_n;

    olb_stream_if #(.payload_t(item_t))      item_ch ();
    olb_stream_if #(.payload_t(result_t))    result_ch ();
    olb_stream_if #(.payload_t(cfg_write_t)) cfg_ch ();

    lockable_output_bank u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Predictor state and its copy of the registers
    cfg_t                  bank_cfg;
    logic [BANK_WIDTH-1:0] level_state;
    logic [BANK_WIDTH-1:0] lock_state;

    item_t   pending_frames[$];
    result_t expected_snapshots[$];

    int frames_queued;
    int frames_accepted;
    int frames_acted;
    int status_requests;
    int snapshots_checked;
    int errors;

    int burst_left;
    int gap_left;
    int stall_left;
    int stall_mode;
    int mon_cycle;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_error(input string msg);
        errors++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_error($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Applies one accepted transaction to the predicted bank and returns the snapshot.
    function automatic result_t apply_frame(input item_t it);
        logic [BANK_WIDTH-1:0] sel;
        logic [BANK_WIDTH-1:0] upd;
        result_t               snap;
        if (it.kind == KIND_STATUS)
        begin
            status_requests++;
        end
        else if (it.frame_id == FRAME_ID_WIDTH'(bank_cfg.device_id) && !it.is_extended &&
                 it.frame_length == FRAME_LEN)
        begin
            frames_acted++;
            sel = it.select_mask & bank_cfg.wired_mask & OUT_MASK;
            case (it.command)
                CMD_SET:
                begin
                    upd         = sel & ~lock_state;
                    level_state = (level_state & ~upd) | (it.value_bits & upd);
                end
                CMD_TOGGLE:
                begin
                    level_state = level_state ^ (sel & ~lock_state);
                end
                CMD_LOCK_SET:
                begin
                    lock_state  = lock_state | sel;
                    level_state = (level_state & ~sel) | (it.value_bits & sel);
                end
                CMD_LOCK_REMOVE:
                begin
                    lock_state = lock_state & ~sel;
                end
                default:
                begin
                end
            endcase
        end
        snap.output_levels   = level_state & bank_cfg.wired_mask;
        snap.lock_mask       = lock_state;
        snap.is_status_reply = (it.kind == KIND_STATUS);
        snap.reply_id        = (it.kind == KIND_STATUS) ?
                               REPLY_ID_WIDTH'(bank_cfg.device_id) + REPLY_ID_WIDTH'(1) : '0;
        return snap;
    endfunction

    function automatic item_t make_frame(input logic [FRAME_ID_WIDTH-1:0] id,
                                         input logic ext, input logic [LEN_WIDTH-1:0] len,
                                         input logic [CMD_WIDTH-1:0] cmd,
                                         input logic [BANK_WIDTH-1:0] sel,
                                         input logic [BANK_WIDTH-1:0] val);
        item_t it;
        it.kind         = KIND_FRAME;
        it.frame_id     = id;
        it.is_extended  = ext;
        it.frame_length = len;
        it.command      = cmd;
        it.select_mask  = sel;
        it.value_bits   = val;
        return it;
    endfunction

    // Status request with junk in the frame fields, which must be ignored
    function automatic item_t make_status();
        item_t it;
        it.kind         = KIND_STATUS;
        it.frame_id     = FRAME_ID_WIDTH'($urandom);
        it.is_extended  = 1'($urandom);
        it.frame_length = LEN_WIDTH'($urandom);
        it.command      = CMD_WIDTH'($urandom);
        it.select_mask  = BANK_WIDTH'($urandom);
        it.value_bits   = BANK_WIDTH'($urandom);
        return it;
    endfunction

    function automatic logic [BANK_WIDTH-1:0] random_mask();
        int pick;
        pick = $urandom_range(19);
        if (pick < 2)
            return '1;
        else if (pick == 2)
            return '0;
        else if (pick < 6)
            return BANK_WIDTH'(1) << $urandom_range(BANK_WIDTH - 1);
        else
            return BANK_WIDTH'($urandom);
    endfunction

    // Mostly well-formed frames for our id; the rest status requests and near misses.
    function automatic item_t random_frame();
        item_t it;
        int    pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return make_status();
        it = make_frame(FRAME_ID_WIDTH'(bank_cfg.device_id), 1'b0, FRAME_LEN,
                        ($urandom_range(9) < 8) ? CMD_WIDTH'($urandom_range(3)) :
                                                  CMD_WIDTH'($urandom_range(4, 7)),
                        random_mask(), random_mask());
        if (pick >= 78)
        begin
            case ($urandom_range(3))
                0: it.frame_id = FRAME_ID_WIDTH'($urandom);
                1: it.frame_id = it.frame_id ^ (FRAME_ID_WIDTH'(1) <<
                                                $urandom_range(FRAME_ID_WIDTH - 1));
                2: it.is_extended = 1'b1;
                default:
                begin
                    it.frame_length = LEN_WIDTH'($urandom_range(14));
                    if (it.frame_length >= FRAME_LEN)
                        it.frame_length = it.frame_length + LEN_WIDTH'(1);
                end
            endcase
        end
        return it;
    endfunction

    task automatic queue_frame(input item_t it);
        pending_frames.push_back(it);
        frames_queued++;
    endtask

    // Keeps valid high across back-to-back writes; the caller lowers it.
    task automatic write_reg(input logic idx, input logic [BANK_WIDTH-1:0] data);
        cfg_write_t w;
        w.index = idx;
        w.data  = data;
        cfg_ch.payload <= w;
        cfg_ch.valid   <= 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
        if (idx == REG_DEVICE_ID)
            bank_cfg.device_id = data[ID_WIDTH-1:0];
        else
            bank_cfg.wired_mask = data;
    endtask

    task automatic configure(input logic [ID_WIDTH-1:0] id,
                             input logic [BANK_WIDTH-1:0] wired);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(REG_DEVICE_ID, {junk[BANK_WIDTH-ID_WIDTH-1:0], id});
        write_reg(REG_WIRED_MASK, wired);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        while (frames_accepted != frames_queued || expected_snapshots.size() != 0)
            @(posedge clk);
    endtask

    // Item driver: bursts of random length with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                expected_snapshots.push_back(apply_frame(item_ch.payload));
                frames_accepted++;
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    item_ch.valid <= 1'b0;
                end
                else if (pending_frames.size() != 0)
                begin
                    item_ch.payload <= pending_frames.pop_front();
                    item_ch.valid   <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 5);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each transaction, stalls in modes that change over time
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_snapshots.size() == 0)
                begin
                    report_error("result transaction with no expectation waiting");
                end
                else
                begin
                    check_field("output_levels", 32'(result_ch.payload.output_levels),
                                32'(expected_snapshots[0].output_levels));
                    check_field("lock_mask", 32'(result_ch.payload.lock_mask),
                                32'(expected_snapshots[0].lock_mask));
                    check_field("is_status_reply", 32'(result_ch.payload.is_status_reply),
                                32'(expected_snapshots[0].is_status_reply));
                    check_field("reply_id", 32'(result_ch.payload.reply_id),
                                32'(expected_snapshots[0].reply_id));
                    void'(expected_snapshots.pop_front());
                    snapshots_checked++;
                end
            end
            mon_cycle++;
            if (mon_cycle % 300 == 0)
                stall_mode = $urandom_range(2);
            if (stall_left != 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (stall_mode == 0)
            begin
                result_ch.ready <= 1'b1;
            end
            else if (stall_mode == 1)
            begin
                result_ch.ready <= ($urandom_range(3) != 0);
            end
            else if ($urandom_range(9) == 0)
            begin
                stall_left = $urandom_range(1, 12);
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #500_000;
        $display("timeout: %0d of %0d transactions accepted", frames_accepted, frames_queued);
        $display("lockable_output_bank regression: fail");
        $finish;
    end

    initial
    begin
        logic [ID_WIDTH-1:0]   id;
        logic [BANK_WIDTH-1:0] wired;
        rst_n           = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.payload = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.payload  = '0;
        bank_cfg        = '0;
        level_state     = '0;
        lock_state      = '0;
        burst_left      = 1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every command, locks against set/toggle, and each rejection path
        configure('0, '1);
        queue_frame(make_status());
        queue_frame(make_frame('0, 1'b0, FRAME_LEN, CMD_SET, '1, '1));
        queue_frame(make_frame('0, 1'b0, FRAME_LEN, CMD_TOGGLE, 24'h00FF00, '0));
        queue_frame(make_frame('0, 1'b0, FRAME_LEN, CMD_LOCK_SET, 24'hF0000F, 24'h80000A));
        queue_frame(make_frame('0, 1'b0, FRAME_LEN, CMD_SET, '1, '0));
        queue_frame(make_frame('0, 1'b0, FRAME_LEN, CMD_TOGGLE, '1, '0));
        queue_frame(make_frame('0, 1'b0, FRAME_LEN, CMD_LOCK_REMOVE, 24'h00000F, '0));
        for (int c = 4; c < 8; c++)
            queue_frame(make_frame('0, 1'b0, FRAME_LEN, CMD_WIDTH'(c), '1, '0));
        queue_frame(make_frame('0, 1'b0, FRAME_LEN, CMD_SET, '0, '0));
        queue_frame(make_frame('1, 1'b0, FRAME_LEN, CMD_SET, '1, '0));
        queue_frame(make_frame(29'h800, 1'b0, FRAME_LEN, CMD_SET, '1, '0));
        queue_frame(make_frame('0, 1'b1, FRAME_LEN, CMD_SET, '1, '0));
        queue_frame(make_frame('0, 1'b0, 4'd0, CMD_SET, '1, '0));
        queue_frame(make_frame('0, 1'b0, 4'd6, CMD_TOGGLE, '1, '0));
        queue_frame(make_frame('0, 1'b0, 4'd8, CMD_TOGGLE, '1, '0));
        queue_frame(make_frame('0, 1'b0, 4'd15, CMD_LOCK_SET, '1, '1));
        queue_frame(make_frame('0, 1'b0, FRAME_LEN, CMD_LOCK_REMOVE, '1, '0));
        queue_frame(make_status());
        wait_idle();

        // Unwired outputs keep their level but read low
        configure('1, 24'h0F0F0F);
        queue_frame(make_status());
        queue_frame(make_frame(29'h7FF, 1'b0, FRAME_LEN, CMD_SET, '1, '1));
        queue_frame(make_frame(29'h7FF, 1'b0, FRAME_LEN, CMD_LOCK_SET, '1, 24'hAAAAAA));
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: begin id = '1;                     wired = '1; end
                1: begin id = ID_WIDTH'($urandom);    wired = BANK_WIDTH'($urandom); end
                2: begin id = ID_WIDTH'($urandom);    wired = '0; end
                3: begin id = '0;                     wired = BANK_WIDTH'($urandom); end
                4: begin id = ID_WIDTH'($urandom);    wired = BANK_WIDTH'($urandom); end
                default: begin id = ID_WIDTH'($urandom); wired = '1; end
            endcase
            configure(id, wired);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                queue_frame(random_frame());
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (expected_snapshots.size() != 0)
            report_error($sformatf("%0d expected results never arrived",
                                   expected_snapshots.size()));
        $display("covered %0d transactions over %0d register settings: %0d frames acted on,",
                 frames_accepted, RANDOM_PHASES + 2, frames_acted);
        $display("%0d status requests, %0d results compared, %0d errors",
                 status_requests, snapshots_checked, errors);
        if (errors == 0)
            $display("lockable_output_bank regression: pass");
        else
            $display("lockable_output_bank regression: fail");
        $finish;
    end

endmodule
